// ===== design/epia_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and state type for the event polarity image accumulator.
// No dependencies.
package epia_pkg;

  localparam int PIX_INDEX_BITS = 16;
  localparam int COUNT_BITS     = 16;
  localparam int GREY_BITS      = 8;
  localparam int MAX_PIX_DEPTH  = 65536;

  localparam int DEF_IMAGE_WIDTH  = 256;
  localparam int DEF_IMAGE_HEIGHT = 256;
  localparam int DEF_SUM_BITS     = 24;

  localparam logic [GREY_BITS-1:0] GREY_ZERO    = 8'd0;
  localparam logic [GREY_BITS-1:0] GREY_NEUTRAL = 8'd127;
  localparam logic [GREY_BITS-1:0] GREY_FULL    = 8'd255;

  localparam logic FUNC_ACC  = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam logic POL_ON    = 1'b0;
  localparam logic POL_OFF   = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DIV,
    S_DONE
  } epia_state_t;

endpackage

// ===== design/epia_div.sv =====
`timescale 1ns / 1ps
// Restoring divider for the ratio grey level: floor(on*255/total), one quotient bit a cycle.
// Depends on epia_pkg.
module epia_div #(
  parameter int SUM_BITS = epia_pkg::DEF_SUM_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [SUM_BITS-1:0]           on_sum,
  input  logic [SUM_BITS:0]             total,
  output logic                          done,
  output logic [epia_pkg::GREY_BITS-1:0] quotient
);
  import epia_pkg::*;

  localparam int NUM_BITS  = SUM_BITS + GREY_BITS;
  localparam int STEP_BITS = $clog2(GREY_BITS);

  logic [NUM_BITS-1:0]  rem;
  logic [SUM_BITS:0]    den;
  logic [STEP_BITS-1:0] step;
  logic                 busy;
  logic [NUM_BITS-1:0]  trial;

  assign trial = NUM_BITS'(den) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {on_sum, {GREY_BITS{1'b0}}} - NUM_BITS'(on_sum);
      den      <= total;
      step     <= STEP_BITS'(GREY_BITS - 1);
      quotient <= '0;
    end else if (busy) begin
      if (rem >= trial) begin
        rem            <= rem - trial;
        quotient[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

endmodule

// ===== design/event_polarity_image_accumulator_top.sv =====
`timescale 1ns / 1ps
// Event polarity image accumulator: per-pixel ON/OFF saturating sums in one memory.
// Depends on epia_pkg and epia_div.

// After reset the block sweeps its sum memory to zero, one pixel a cycle over the
// min(IMAGE_WIDTH*IMAGE_HEIGHT, 65536) pixels, 65536 at the defaults, and takes no
// beat until then. Beats are then handled one at a time through a read-modify-write
// of the pixel memory: an accumulate beat passes idle and lookup (idle drops it if the
// pixel lies outside the image), a read beat idle, lookup and done (idle goes to done
// for an outside pixel), and in ratio mode with a nonzero total also the divide
// state, where an 8-step restoring divider forms the ratio. Read results wait in an
// output register, so the next beat may enter while a result is still pending; a read
// that finishes while it is still full waits in done until the pending result is taken.
module event_polarity_image_accumulator_top #(
  parameter int IMAGE_WIDTH  = epia_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = epia_pkg::DEF_IMAGE_HEIGHT,
  parameter int SUM_BITS     = epia_pkg::DEF_SUM_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // ratio_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // pixel_index[15:0], count[31:16]
  input  logic [1:0]  s_tuser,       // func[0], polarity[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata        // out_pixel_index[15:0], pixel_value[23:16]
);
  import epia_pkg::*;

  localparam int unsigned NPIX = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int unsigned PIX_DEPTH = (NPIX > MAX_PIX_DEPTH) ? MAX_PIX_DEPTH : NPIX;
  localparam int ADDR_BITS = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int ACC_BITS  = ((SUM_BITS > COUNT_BITS) ? SUM_BITS : COUNT_BITS) + 1;
  localparam int WORD_BITS = 2 * SUM_BITS;

  logic [WORD_BITS-1:0] mem [PIX_DEPTH];
  logic [WORD_BITS-1:0] rd_data;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [ADDR_BITS-1:0] mem_raddr;

  epia_state_t state, state_next;

  logic                      ratio_mode;
  logic [ADDR_BITS-1:0]      clr_addr;
  logic                      item_func;
  logic                      item_pol;
  logic [COUNT_BITS-1:0]     item_count;
  logic [PIX_INDEX_BITS-1:0] item_index;
  logic [GREY_BITS-1:0]      res_value;

  logic                      in_func;
  logic                      in_pol;
  logic [PIX_INDEX_BITS-1:0] in_index;
  logic [COUNT_BITS-1:0]     in_count;
  logic                      in_accept;
  logic                      in_inside;
  logic                      load_out;

  logic [SUM_BITS-1:0] on_old;
  logic [SUM_BITS-1:0] off_old;
  logic [SUM_BITS:0]   total;
  logic [ACC_BITS-1:0] acc_sum;
  logic [SUM_BITS-1:0] acc_sat;
  logic [GREY_BITS-1:0] cmp_value;

  logic                 div_start;
  logic                 div_done;
  logic [GREY_BITS-1:0] div_q;

  assign in_func   = s_tuser[0];
  assign in_pol    = s_tuser[1];
  assign in_index  = s_tdata[15:0];
  assign in_count  = s_tdata[31:16];
  assign in_accept = s_tvalid && s_tready;
  assign in_inside = 32'(in_index) < 32'(NPIX);
  assign mem_raddr = in_index[ADDR_BITS-1:0];

  assign on_old  = rd_data[SUM_BITS-1:0];
  assign off_old = rd_data[WORD_BITS-1:SUM_BITS];
  assign total   = {1'b0, on_old} + {1'b0, off_old};
  assign acc_sum = ACC_BITS'(item_pol == POL_ON ? on_old : off_old) + ACC_BITS'(item_count);
  assign acc_sat = (acc_sum > ACC_BITS'({SUM_BITS{1'b1}})) ? {SUM_BITS{1'b1}}
                                                            : acc_sum[SUM_BITS-1:0];
  assign cmp_value = (on_old > off_old) ? GREY_FULL :
                     (on_old < off_old) ? GREY_ZERO : GREY_NEUTRAL;

  assign load_out = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = item_index[ADDR_BITS-1:0];
    mem_wdata  = '0;
    div_start  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == ADDR_BITS'(PIX_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_inside) begin
            state_next = S_LOOKUP;
          end else if (in_func == FUNC_READ) begin
            state_next = S_DONE;
          end
        end
      end
      S_LOOKUP: begin
        mem_we = 1'b1;
        if (item_func == FUNC_ACC) begin
          mem_wdata  = (item_pol == POL_ON) ? {off_old, acc_sat} : {acc_sat, on_old};
          state_next = S_IDLE;
        end else if (ratio_mode && total != '0) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_mode <= 1'b0;
      clr_addr   <= '0;
    end else begin
      if (cfg_wr_en) begin
        ratio_mode <= cfg_wr_data;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_func  <= in_func;
      item_pol   <= in_pol;
      item_count <= in_count;
      item_index <= in_index;
      res_value  <= GREY_NEUTRAL;
    end else if (state == S_LOOKUP) begin
      res_value <= ratio_mode ? GREY_NEUTRAL : cmp_value;
    end else if (state == S_DIV && div_done) begin
      res_value <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {res_value, item_index};
    end
  end

  epia_div #(
    .SUM_BITS (SUM_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .on_sum   (on_old),
    .total    (total),
    .done     (div_done),
    .quotient (div_q)
  );

  a_acc_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_func == FUNC_ACC) |=> !$rose(m_tvalid))
    else $error("result raised after accumulate beat");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_LOOKUP))
    else $error("memory write outside clear or lookup");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (mem_wdata == '0 && !s_tready))
    else $error("clear pass writes nonzero or accepts a beat");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

endmodule

// ===== sim/event_polarity_image_accumulator_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for event_polarity_image_accumulator_top: tracks per-pixel ON/OFF sums
// and the grey mode, then checks every read result in order. Depends on epia_pkg and the RTL.
module event_polarity_image_accumulator_top_test;
  import epia_pkg::*;

  localparam int IMAGE_WIDTH  = DEF_IMAGE_WIDTH;
  localparam int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT;
  localparam int SUM_BITS     = DEF_SUM_BITS;
  localparam int IDLE_LIMIT   = 300000;
  localparam int PHASE_BEATS  = 190;

  typedef struct packed {
    logic [GREY_BITS-1:0]      grey;
    logic [PIX_INDEX_BITS-1:0] pix;
  } grey_beat_t;

  class pixel_sum_tracker;
    bit [63:0]  sum_max;
    bit [31:0]  on_sum [MAX_PIX_DEPTH];
    bit [31:0]  off_sum [MAX_PIX_DEPTH];
    bit         ratio_mode;
    grey_beat_t awaited[$];
    int         mismatches;

    function new();
      sum_max = (64'd1 << SUM_BITS) - 64'd1;
    endfunction

    function bit [7:0] grey_level(bit [31:0] on_cnt, bit [31:0] off_cnt);
      bit [63:0] on_w;
      bit [63:0] total;
      on_w  = on_cnt;
      total = on_w + off_cnt;
      if (ratio_mode) begin
        if (total == 0) return GREY_NEUTRAL;
        return 8'((on_w * 255) / total);
      end
      if (on_cnt > off_cnt) return GREY_FULL;
      if (on_cnt < off_cnt) return GREY_ZERO;
      return GREY_NEUTRAL;
    endfunction

    function void note_beat(logic func, logic [15:0] pix, logic pol, logic [15:0] cnt);
      bit         inside_img;
      bit [63:0]  sum;
      grey_beat_t res;
      inside_img = pix < IMAGE_WIDTH * IMAGE_HEIGHT;
      if (func == FUNC_ACC) begin
        if (!inside_img) return;
        sum = (pol == POL_ON) ? on_sum[pix] : off_sum[pix];
        sum = sum + cnt;
        if (sum > sum_max) sum = sum_max;
        if (pol == POL_ON) on_sum[pix] = sum[31:0];
        else off_sum[pix] = sum[31:0];
        return;
      end
      res.pix = pix;
      if (inside_img) begin
        res.grey = grey_level(on_sum[pix], off_sum[pix]);
        on_sum[pix]  = 0;
        off_sum[pix] = 0;
      end else begin
        res.grey = GREY_NEUTRAL;
      end
      awaited.push_back(res);
    endfunction

    function void check_pixel(logic [23:0] data);
      grey_beat_t want;
      grey_beat_t got;
      got = data;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat, pixel %0d value %0d", $time, got.pix, got.grey);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.pix !== want.pix) begin
        $display("%0t: out_pixel_index expected %0d actual %0d", $time, want.pix, got.pix);
        mismatches++;
      end
      if (got.grey !== want.grey) begin
        $display("%0t: pixel_value of pixel %0d expected %0d actual %0d", $time, want.pix,
                 want.grey, got.grey);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;      // pixel_index[15:0], count[31:16]
  logic [1:0]  s_tuser = '0;      // func[0], polarity[1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // out_pixel_index[15:0], pixel_value[23:16]

  pixel_sum_tracker tracker;
  bit               steady;
  int               beats_sent;
  int               idle_cycles;
  logic [15:0]      hot_pixels [8];

  event_polarity_image_accumulator_top #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .SUM_BITS    (SUM_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input logic func, input logic [15:0] pix, input logic pol,
                           input logic [15:0] cnt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {cnt, pix};
    s_tuser  <= {pol, func};
    do @(posedge clk); while (!s_tready);
    tracker.note_beat(func, pix, pol, cnt);
    beats_sent++;
  endtask

  // hold off until every read result is back, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_ratio_mode(input logic ratio);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ratio;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.ratio_mode = ratio;
  endtask

  task automatic run_burst();
    logic [15:0] pix;
    logic [15:0] cnt;
    int          kind;
    int          pick;
    kind = $urandom_range(0, 9);
    pick = $urandom_range(0, 9);
    if (pick == 0) pix = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else if (pick < 3) pix = 16'($urandom);
    else pix = hot_pixels[$urandom_range(0, 7)];
    if (kind == 0) begin
      send_beat(1'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
    end else if (kind == 1) begin
      send_beat(FUNC_READ, pix, 1'($urandom), 16'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 7))
          0:       cnt = 16'd0;
          1:       cnt = 16'hFFFF;
          2, 3, 4: cnt = 16'($urandom_range(1, 15));
          default: cnt = 16'($urandom);
        endcase
        send_beat(FUNC_ACC, pix, 1'($urandom), cnt);
      end
      // leave some pixels unread so later bursts stack on them
      if ($urandom_range(0, 6) != 0) send_beat(FUNC_READ, pix, 1'($urandom), 16'($urandom));
    end
  endtask

  // result side: check accepted beats, stall at random
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_pixel(m_tdata);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int target;
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // compare mode
    set_ratio_mode(1'b0);
    send_beat(FUNC_ACC, 16'h0000, POL_ON, 16'hFFFF);
    send_beat(FUNC_ACC, 16'h0000, POL_OFF, 16'h0001);
    send_beat(FUNC_READ, 16'h0000, 1'b0, 16'h0000);
    send_beat(FUNC_ACC, 16'hFFFF, POL_OFF, 16'hFFFF);
    send_beat(FUNC_READ, 16'hFFFF, 1'b1, 16'hFFFF);
    send_beat(FUNC_READ, 16'h0000, 1'b0, 16'h0000);
    send_beat(FUNC_ACC, 16'h5A5A, POL_ON, 16'd7);
    send_beat(FUNC_ACC, 16'h5A5A, POL_OFF, 16'd7);
    send_beat(FUNC_READ, 16'h5A5A, 1'b0, 16'h0000);
    send_beat(FUNC_ACC, 16'hA5A5, POL_ON, 16'h0000);
    send_beat(FUNC_READ, 16'hA5A5, 1'b0, 16'h0000);

    // ratio mode
    set_ratio_mode(1'b1);
    send_beat(FUNC_READ, 16'h1234, 1'b0, 16'h0000);
    send_beat(FUNC_ACC, 16'h1234, POL_ON, 16'd1);
    send_beat(FUNC_ACC, 16'h1234, POL_OFF, 16'd2);
    send_beat(FUNC_READ, 16'h1234, 1'b0, 16'h0000);
    send_beat(FUNC_ACC, 16'hFFFF, POL_ON, 16'hFFFF);
    send_beat(FUNC_READ, 16'hFFFF, 1'b0, 16'h0000);
    send_beat(FUNC_ACC, 16'h0000, POL_OFF, 16'hFFFF);
    send_beat(FUNC_READ, 16'h0000, 1'b0, 16'h0000);
    send_beat(FUNC_ACC, 16'h00FF, POL_ON, 16'd3);
    send_beat(FUNC_ACC, 16'h00FF, POL_OFF, 16'd3);
    send_beat(FUNC_READ, 16'h00FF, 1'b1, 16'h0000);

    for (int phase = 0; phase < 4; phase++) begin
      set_ratio_mode(phase[0]);
      steady = (phase == 2);
      foreach (hot_pixels[i]) hot_pixels[i] = 16'($urandom);
      if (phase == 1) begin
        // drive the ON sum into saturation
        repeat (257) send_beat(FUNC_ACC, hot_pixels[0], POL_ON, 16'hFFFF);
        send_beat(FUNC_ACC, hot_pixels[0], POL_OFF, 16'd9);
        send_beat(FUNC_READ, hot_pixels[0], 1'($urandom), 16'($urandom));
      end
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) run_burst();
    end

    steady = 1'b0;
    settle();
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
